// ===== rtl/etpq_pkg.sv =====
// Shared types and constants for the event time priority queue.
// No dependencies; every other file imports this package.
`default_nettype none
package etpq_pkg;

   localparam int DEPTH    = 16;
   localparam int TIME_W   = 32;
   localparam int HANDLE_W = 16;
   localparam int OCC_W    = $clog2(DEPTH + 1);

   localparam logic OP_SCHEDULE = 1'b0;
   localparam logic OP_POP      = 1'b1;

   typedef struct packed {
      logic                insert;
      logic                pop;
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] handle;
   } cell_ctrl_type;

   typedef struct packed {
      logic                used;
      logic [TIME_W-1:0]   stamp;
      logic [HANDLE_W-1:0] handle;
      logic                ge;
      logic                shift;
   } cell_link_type;

   localparam cell_link_type LEFT_EDGE = '{
      used: 1'b1, stamp: '0, handle: '0, ge: 1'b0, shift: 1'b0};
   localparam cell_link_type RIGHT_EDGE = '{
      used: 1'b0, stamp: '0, handle: '0, ge: 1'b1, shift: 1'b1};

endpackage
`default_nettype wire

// ===== rtl/etpq_ifs.sv =====
// Channel interfaces of the event time priority queue: request, response, csr.
// Depends on etpq_pkg for field widths.
`default_nettype none
interface etpq_req_if import etpq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic [TIME_W-1:0]   event_stamp;
   logic [HANDLE_W-1:0] event_handle;
   modport source (output valid, op, event_stamp, event_handle, input ready);
   modport sink   (input valid, op, event_stamp, event_handle, output ready);
endinterface

interface etpq_rsp_if import etpq_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                popped_valid;
   logic [TIME_W-1:0]   popped_stamp;
   logic [HANDLE_W-1:0] popped_handle;
   logic                past_end;
   logic                insert_rejected;
   logic [TIME_W-1:0]   current_time;
   logic [OCC_W-1:0]    occupancy;
   modport source (output valid, popped_valid, popped_stamp, popped_handle, past_end,
                   insert_rejected, current_time, occupancy, input ready);
   modport sink   (input valid, popped_valid, popped_stamp, popped_handle, past_end,
                   insert_rejected, current_time, occupancy, output ready);
endinterface

interface etpq_csr_if import etpq_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] data;
   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/event_time_priority_queue.sv =====
// Top level of the event time priority queue: a row of etpq_cell slots.
// Depends on etpq_pkg, etpq_ifs and etpq_cell.
//
// Requests arrive on req_if: op selects schedule or pop, event_stamp and
// event_handle give the entry. Each request gives exactly one response on
// rsp_if, registered, in the cycle after the request is taken. A new request is
// taken every cycle while the response register is empty or being drained,
// so the block sustains one request per cycle; a stalled rsp_if holds the
// response and req_if.ready drops until it leaves.
// Schedule shifts the entries behind the insertion point one slot right in
// all cells at once; pop shifts every entry one slot left. A schedule into
// a full queue is dropped and flagged.
// csr_if writes end_time at any time it is valid; ready is high outside reset.
// Reset empties the queue, clears the current time and sets end_time to all
// ones. No clearing pass runs; the block is ready as soon as reset drops.
`default_nettype none
module event_time_priority_queue import etpq_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   etpq_req_if.sink   req_if,
   etpq_rsp_if.source rsp_if,
   etpq_csr_if.sink   csr_if
);

   cell_link_type       links [DEPTH];
   cell_ctrl_type       ctrl;
   logic                take, full, empty, do_pop;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [TIME_W-1:0]   sim_time_ff, sim_time_in;
   logic [TIME_W-1:0]   end_time_ff;
   logic                rsp_valid_ff;
   logic                popped_valid_ff, popped_valid_in;
   logic [TIME_W-1:0]   popped_stamp_ff, popped_stamp_in;
   logic [HANDLE_W-1:0] popped_handle_ff, popped_handle_in;
   logic                past_end_ff, past_end_in;
   logic                rejected_ff, rejected_in;

   assign req_if.ready = !reset && (!rsp_valid_ff || rsp_if.ready);
   assign csr_if.ready = !reset;
   assign take  = req_if.valid && req_if.ready;
   assign full  = occ_ff == OCC_W'(DEPTH);
   assign empty = occ_ff == '0;
   assign do_pop = take && (req_if.op == OP_POP) && !empty;

   assign ctrl = '{insert: take && (req_if.op == OP_SCHEDULE) && !full,
                   pop:    do_pop,
                   stamp:  req_if.event_stamp,
                   handle: req_if.event_handle};

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0 && i == DEPTH - 1) begin : g_only
         etpq_cell u_cell (.clock, .reset, .ctrl, .from_left(LEFT_EDGE),
                           .from_right(RIGHT_EDGE), .link(links[i]));
      end else if (i == 0) begin : g_first
         etpq_cell u_cell (.clock, .reset, .ctrl, .from_left(LEFT_EDGE),
                           .from_right(links[i+1]), .link(links[i]));
      end else if (i == DEPTH - 1) begin : g_last
         etpq_cell u_cell (.clock, .reset, .ctrl, .from_left(links[i-1]),
                           .from_right(RIGHT_EDGE), .link(links[i]));
      end else begin : g_mid
         etpq_cell u_cell (.clock, .reset, .ctrl, .from_left(links[i-1]),
                           .from_right(links[i+1]), .link(links[i]));
      end
   end

   always_comb begin
      occ_in           = occ_ff;
      sim_time_in      = sim_time_ff;
      popped_valid_in  = 1'b0;
      popped_stamp_in  = '0;
      popped_handle_in = '0;
      past_end_in      = 1'b0;
      rejected_in      = 1'b0;
      if (ctrl.insert) begin
         occ_in = occ_ff + OCC_W'(1);
      end
      if (take && (req_if.op == OP_SCHEDULE) && full) begin
         rejected_in = 1'b1;
      end
      if (do_pop) begin
         occ_in           = occ_ff - OCC_W'(1);
         sim_time_in      = links[0].stamp;
         popped_valid_in  = 1'b1;
         popped_stamp_in  = links[0].stamp;
         popped_handle_in = links[0].handle;
         past_end_in      = links[0].stamp >= end_time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff       <= '0;
         sim_time_ff  <= '0;
         end_time_ff  <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         occ_ff      <= occ_in;
         sim_time_ff <= sim_time_in;
         if (csr_if.valid) begin
            end_time_ff <= csr_if.data;
         end
         if (take) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (take) begin
         popped_valid_ff  <= popped_valid_in;
         popped_stamp_ff  <= popped_stamp_in;
         popped_handle_ff <= popped_handle_in;
         past_end_ff      <= past_end_in;
         rejected_ff      <= rejected_in;
      end
   end

   assign rsp_if.valid           = rsp_valid_ff;
   assign rsp_if.popped_valid    = popped_valid_ff;
   assign rsp_if.popped_stamp    = popped_stamp_ff;
   assign rsp_if.popped_handle   = popped_handle_ff;
   assign rsp_if.past_end        = past_end_ff;
   assign rsp_if.insert_rejected = rejected_ff;
   assign rsp_if.current_time    = sim_time_ff;
   assign rsp_if.occupancy       = occ_ff;

endmodule
`default_nettype wire

// ===== rtl/etpq_cell.sv =====
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
// Depends on etpq_pkg for the control and link structs.
`default_nettype none
module etpq_cell import etpq_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire cell_link_type from_left,
   input  wire cell_link_type from_right,
   output cell_link_type      link
);

   logic                used_ff, used_in;
   logic [TIME_W-1:0]   stamp_ff, stamp_in;
   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic                ge, eq, shift;

   assign ge    = !used_ff || (stamp_ff >= ctrl.stamp);
   assign eq    = used_ff && (stamp_ff == ctrl.stamp);
   assign shift = from_left.ge || (ge && !eq);

   always_comb begin
      used_in   = used_ff;
      stamp_in  = stamp_ff;
      handle_in = handle_ff;
      if (ctrl.insert) begin
         used_in = from_left.used;
         if (from_left.shift) begin
            stamp_in  = from_left.stamp;
            handle_in = from_left.handle;
         end else if (shift) begin
            stamp_in  = ctrl.stamp;
            handle_in = ctrl.handle;
         end
      end else if (ctrl.pop) begin
         used_in   = from_right.used;
         stamp_in  = from_right.stamp;
         handle_in = from_right.handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else begin
         used_ff <= used_in;
      end
      stamp_ff  <= stamp_in;
      handle_ff <= handle_in;
   end

   assign link = '{used: used_ff, stamp: stamp_ff, handle: handle_ff, ge: ge, shift: shift};

endmodule
`default_nettype wire
